// File: design/gcaf_pkg.sv
// Shared types, constants and helper functions of the gated complementary attitude filter.
package gcaf_pkg;

  // Field widths and fixed-point formats
  localparam int AccW        = 16;
  localparam int EstW        = 24;
  localparam int LpW         = 32;
  localparam int LpFracBits  = 16;
  localparam int EstFracBits = 8;

  // Stream payload widths
  localparam int InDataW  = 240;
  localparam int OutDataW = 208;

  // Payload field offsets
  localparam int MagLsb  = 48;
  localparam int GravLsb = 96;
  localparam int MagvLsb = 168;

  // Shared divider sizes
  localparam int DivNumW = 40;
  localparam int DivDenW = 30;
  localparam int DivCntW = 6;

  // Gate and scaling constants
  localparam int MagLowPct  = 36;
  localparam int MagHighPct = 196;
  localparam int PctScale   = 100;
  localparam int TiltNum    = 423;
  localparam int TiltDen    = 1000;
  localparam int MagPctMax  = 1023;

  // Divide by 1000 as multiply by ceil(2^34/1000) and shift; exact below 2^24
  localparam logic [24:0] TiltRecip = 25'd17179870;
  localparam int          TiltShift = 34;

  // Register reset values
  localparam logic [10:0] LpfFactorRst = 11'd100;
  localparam logic [11:0] GravWRst     = 12'd400;
  localparam logic [11:0] MagWRst      = 12'd200;
  localparam logic [14:0] OneGRst      = 15'd512;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ACC_LPF_FACTOR       = 2'd0,
    REG_GRAVITY_GYRO_WEIGHT  = 2'd1,
    REG_MAGNETIC_GYRO_WEIGHT = 2'd2,
    REG_ONE_G_COUNTS         = 2'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LP_DIV,
    ST_LP_WAIT,
    ST_MUL,
    ST_MAG_DIV,
    ST_MAG_WAIT,
    ST_TILT_DIV,
    ST_GATE,
    ST_BL_MUL,
    ST_BL_DIV,
    ST_BL_WAIT,
    ST_OUT
  } state_e;

  // Clamp a 41-bit signed value to 24 bits
  function automatic logic signed [23:0] sat24(logic signed [40:0] v);
    logic signed [23:0] r;
    if (v > 41'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -41'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Clamp a 35-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/gated_complementary_attitude_filter_top.sv
// Top level of the gated complementary attitude filter: sequencer and datapath.
//
// Usage:
//   s_axis_* carries one sample item (accelerometer, magnetometer and the
//   gyro-rotated gravity and magnetic estimates). m_axis_* returns one result
//   item per sample: updated estimates, smoothed acceleration, magnitude
//   percent and the acc_used flag. cfg_* writes the four registers; it is
//   always ready and should only be written while no item is in flight.
// Timing:
//   One item is worked at a time. All variable divisions go through one shared
//   restoring divider at one quotient bit per cycle (10 divisions per item);
//   the tilt threshold uses a reciprocal multiply and the other multiplies
//   share one step each. s_axis_tready is high again the cycle after the
//   result is taken.
// Reset:
//   rst_ni clears the low-pass state to zero and loads register defaults.
// Stall:
//   The result holds on m_axis_tdata while m_axis_tready is low, and no new
//   item is accepted until it is taken.
module gated_complementary_attitude_filter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, grav_in_x/y/z, magv_in_x/y/z
  input  logic [gcaf_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // grav_out_x/y/z, magv_out_x/y/z, smooth_acc_x/y/z, magnitude_percent,
  // acc_used, zero pad
  output logic [gcaf_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_addr_i,
  input  logic [14:0]                     cfg_data_i
);

  gcaf_pkg::state_e state_q, state_d;
  logic [2:0]                    idx_q, idx_d;
  logic [gcaf_pkg::InDataW-1:0]  in_q, in_d;
  logic signed [31:0]            lp_q [3];
  logic signed [31:0]            lp_d [3];
  logic signed [15:0]            sm_q [3];
  logic signed [15:0]            sm_d [3];
  logic signed [23:0]            res_q [6];
  logic signed [23:0]            res_d [6];
  logic [31:0]                   sumsq_q, sumsq_d;
  logic [38:0]                   num100_q, num100_d;
  logic [29:0]                   gg_q, gg_d;
  logic [23:0]                   g423_q, g423_d;
  logic [13:0]                   tilt_q, tilt_d;
  logic [9:0]                    magp_q, magp_d;
  logic                          band_q, band_d;
  logic                          used_q, used_d;
  logic signed [36:0]            prod_q, prod_d;
  logic                          neg_q, neg_d;
  logic [10:0]                   f_q, f_d;
  logic [11:0]                   wg_q, wg_d;
  logic [11:0]                   wm_q, wm_d;
  logic [14:0]                   g_q, g_d;

  logic                          div_start, div_busy, div_done;
  logic [gcaf_pkg::DivNumW-1:0]  div_num, div_quo;
  logic [gcaf_pkg::DivDenW-1:0]  div_den;

  // Shared divider
  gcaf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcaf_pkg::ST_IDLE;
      idx_q   <= '0;
      f_q     <= gcaf_pkg::LpfFactorRst;
      wg_q    <= gcaf_pkg::GravWRst;
      wm_q    <= gcaf_pkg::MagWRst;
      g_q     <= gcaf_pkg::OneGRst;
      for (int i = 0; i < 3; i++) begin
        lp_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      f_q     <= f_d;
      wg_q    <= wg_d;
      wm_q    <= wm_d;
      g_q     <= g_d;
      for (int i = 0; i < 3; i++) begin
        lp_q[i] <= lp_d[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    sumsq_q  <= sumsq_d;
    num100_q <= num100_d;
    gg_q     <= gg_d;
    g423_q   <= g423_d;
    tilt_q   <= tilt_d;
    magp_q   <= magp_d;
    band_q   <= band_d;
    used_q   <= used_d;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    for (int i = 0; i < 3; i++) begin
      sm_q[i] <= sm_d[i];
    end
    for (int i = 0; i < 6; i++) begin
      res_q[i] <= res_d[i];
    end
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;
  always_comb begin
    f_d  = f_q;
    wg_d = wg_q;
    wm_d = wm_q;
    g_d  = g_q;
    if (cfg_valid_i) begin
      case (gcaf_pkg::reg_idx_e'(cfg_addr_i))
        gcaf_pkg::REG_ACC_LPF_FACTOR:       f_d  = cfg_data_i[10:0];
        gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT:  wg_d = cfg_data_i[11:0];
        gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT: wm_d = cfg_data_i[11:0];
        gcaf_pkg::REG_ONE_G_COUNTS:         g_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_comb begin
    logic [1:0]         ax;
    logic [1:0]         bk;
    logic               grav_sel;
    logic [10:0]        f_eff;
    logic [14:0]        g_eff;
    logic signed [15:0] acc_v;
    logic signed [33:0] diff;
    logic [33:0]        diff_abs;
    logic signed [34:0] step;
    logic signed [34:0] lp_sum;
    logic signed [31:0] lp_new;
    logic signed [32:0] lp_ext;
    logic [32:0]        lp_abs;
    logic signed [16:0] sm_ext;
    logic signed [31:0] sq;
    logic signed [16:0] abs_x, abs_y;
    logic signed [23:0] est;
    logic [11:0]        w;
    logic [12:0]        den;
    logic signed [15:0] smp;
    logic signed [37:0] num38;
    logic [37:0]        num_abs;
    logic signed [40:0] q41;
    logic [48:0]        tilt_prod;

    state_d   = state_q;
    idx_d     = idx_q;
    in_d      = in_q;
    lp_d      = lp_q;
    sm_d      = sm_q;
    res_d     = res_q;
    sumsq_d   = sumsq_q;
    num100_d  = num100_q;
    gg_d      = gg_q;
    g423_d    = g423_q;
    tilt_d    = tilt_q;
    magp_d    = magp_q;
    band_d    = band_q;
    used_d    = used_q;
    prod_d    = prod_q;
    neg_d     = neg_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;

    ax       = idx_q[1:0];
    grav_sel = (idx_q < 3'd3);
    bk       = grav_sel ? idx_q[1:0] : 2'(idx_q - 3'd3);
    f_eff    = (f_q == '0) ? 11'd1 : f_q;
    g_eff    = (g_q == '0) ? 15'd1 : g_q;
    acc_v    = in_q[{ax, 4'b0000} +: gcaf_pkg::AccW];
    diff     = 34'($signed({acc_v, 16'b0})) - 34'(lp_q[ax]);
    diff_abs = diff[33] ? 34'(-diff) : diff;
    step     = neg_q ? -35'(div_quo[33:0]) : 35'(div_quo[33:0]);
    lp_sum   = 35'(lp_q[ax]) + step;
    lp_new   = gcaf_pkg::sat32(lp_sum);
    lp_ext   = 33'(lp_new);
    lp_abs   = lp_ext[32] ? 33'(-lp_ext) : lp_ext;
    sm_ext   = lp_ext[32] ? -17'(lp_abs[32:16]) : 17'(lp_abs[32:16]);
    sq       = sm_q[ax] * sm_q[ax];
    abs_x    = sm_q[0][15] ? -17'(sm_q[0]) : 17'(sm_q[0]);
    abs_y    = sm_q[1][15] ? -17'(sm_q[1]) : 17'(sm_q[1]);
    est      = grav_sel ? in_q[gcaf_pkg::GravLsb + 24 * int'(bk) +: gcaf_pkg::EstW]
                        : in_q[gcaf_pkg::MagvLsb + 24 * int'(bk) +: gcaf_pkg::EstW];
    w        = grav_sel ? wg_q : wm_q;
    den      = 13'(w) + 13'd1;
    smp      = grav_sel ? sm_q[bk] : in_q[gcaf_pkg::MagLsb + 16 * int'(bk) +: gcaf_pkg::AccW];
    num38    = 38'(prod_q) + (38'(smp) <<< gcaf_pkg::EstFracBits);
    num_abs  = num38[37] ? 38'(-num38) : num38;
    q41      = neg_q ? -41'({1'b0, div_quo}) : 41'({1'b0, div_quo});
    tilt_prod = 49'(g423_q) * 49'(gcaf_pkg::TiltRecip);

    case (state_q)
      gcaf_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_d    = s_axis_tdata;
          idx_d   = '0;
          sumsq_d = '0;
          state_d = gcaf_pkg::ST_LP_DIV;
        end
      end
      // Low-pass step: (X - lp) / F
      gcaf_pkg::ST_LP_DIV: begin
        neg_d     = diff[33];
        div_start = 1'b1;
        div_num   = gcaf_pkg::DivNumW'(diff_abs);
        div_den   = gcaf_pkg::DivDenW'(f_eff);
        state_d   = gcaf_pkg::ST_LP_WAIT;
      end
      gcaf_pkg::ST_LP_WAIT: begin
        if (div_done) begin
          lp_d[ax] = lp_new;
          sm_d[ax] = sm_ext[15:0];
          if (ax == 2'd2) begin
            idx_d   = '0;
            state_d = gcaf_pkg::ST_MUL;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = gcaf_pkg::ST_LP_DIV;
          end
        end
      end
      // Squares, scale and threshold products, one per cycle
      gcaf_pkg::ST_MUL: begin
        case (idx_q)
          3'd0, 3'd1, 3'd2: sumsq_d = sumsq_q + 32'(sq);
          3'd3: num100_d = 39'(sumsq_q) * 39'(gcaf_pkg::PctScale);
          3'd4: gg_d = 30'(g_eff) * 30'(g_eff);
          default: g423_d = 24'(g_eff) * 24'(gcaf_pkg::TiltNum);
        endcase
        if (idx_q == 3'd5) begin
          state_d = gcaf_pkg::ST_MAG_DIV;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      gcaf_pkg::ST_MAG_DIV: begin
        div_start = 1'b1;
        div_num   = gcaf_pkg::DivNumW'(num100_q);
        div_den   = gg_q;
        state_d   = gcaf_pkg::ST_MAG_WAIT;
      end
      gcaf_pkg::ST_MAG_WAIT: begin
        if (div_done) begin
          band_d  = (div_quo > 40'(gcaf_pkg::MagLowPct)) &&
                    (div_quo < 40'(gcaf_pkg::MagHighPct));
          magp_d  = (div_quo > 40'(gcaf_pkg::MagPctMax)) ?
                    10'(gcaf_pkg::MagPctMax) : div_quo[9:0];
          state_d = gcaf_pkg::ST_TILT_DIV;
        end
      end
      // Tilt threshold g*423/1000 by reciprocal multiply
      gcaf_pkg::ST_TILT_DIV: begin
        tilt_d  = tilt_prod[gcaf_pkg::TiltShift +: 14];
        state_d = gcaf_pkg::ST_GATE;
      end
      // Magnitude band or small tilt opens the gravity correction
      gcaf_pkg::ST_GATE: begin
        used_d  = band_q || ((abs_x < 17'(tilt_q)) && (abs_y < 17'(tilt_q)) &&
                  (sm_q[2] > 16'sd0));
        idx_d   = '0;
        state_d = gcaf_pkg::ST_BL_MUL;
      end
      // Blend: (est*W + v<<8) / (W+1), rounded half away from zero
      gcaf_pkg::ST_BL_MUL: begin
        prod_d  = 37'(est) * 37'($signed({1'b0, w}));
        state_d = gcaf_pkg::ST_BL_DIV;
      end
      gcaf_pkg::ST_BL_DIV: begin
        neg_d     = num38[37];
        div_start = 1'b1;
        div_num   = gcaf_pkg::DivNumW'(num_abs) + gcaf_pkg::DivNumW'(den[12:1]);
        div_den   = gcaf_pkg::DivDenW'(den);
        state_d   = gcaf_pkg::ST_BL_WAIT;
      end
      gcaf_pkg::ST_BL_WAIT: begin
        if (div_done) begin
          res_d[idx_q] = gcaf_pkg::sat24(q41);
          if (idx_q == 3'd5) begin
            state_d = gcaf_pkg::ST_OUT;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = gcaf_pkg::ST_BL_MUL;
          end
        end
      end
      gcaf_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = gcaf_pkg::ST_IDLE;
        end
      end
      default: state_d = gcaf_pkg::ST_IDLE;
    endcase
  end

  // Handshake and result word
  assign s_axis_tready = (state_q == gcaf_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == gcaf_pkg::ST_OUT);

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[24 * i +: 24]       = used_q ? res_q[i]
                                                : in_q[gcaf_pkg::GravLsb + 24 * i +: 24];
      m_axis_tdata[72 + 24 * i +: 24]  = res_q[3 + i];
      m_axis_tdata[144 + 16 * i +: 16] = sm_q[i];
    end
    m_axis_tdata[201:192] = magp_q;
    m_axis_tdata[202]     = used_q;
  end

  // Never ready for input while a result is pending
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input ready with result pending");

  // Divider completions only arrive in a wait state
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == gcaf_pkg::ST_LP_WAIT || state_q == gcaf_pkg::ST_MAG_WAIT ||
                  state_q == gcaf_pkg::ST_BL_WAIT))
    else $error("divider done outside wait state");

  // Divider requests only when it is free
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider request while busy");

  // Accepted sample starts the low-pass pass
  a_accept_lp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == gcaf_pkg::ST_LP_DIV)
    else $error("accepted item not started");

endmodule

// File: design/gcaf_div.sv
// Shared restoring divider: unsigned, one quotient bit per cycle.
module gcaf_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [gcaf_pkg::DivNumW-1:0]    num_i,
  input  logic [gcaf_pkg::DivDenW-1:0]    den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [gcaf_pkg::DivNumW-1:0]    quo_o
);

  logic                         busy_q, busy_d;
  logic [gcaf_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [gcaf_pkg::DivDenW-1:0] rem_q, rem_d;
  logic [gcaf_pkg::DivDenW-1:0] den_q, den_d;
  logic [gcaf_pkg::DivNumW-1:0] quo_q, quo_d;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // One shift-subtract step per cycle
  always_comb begin
    logic [gcaf_pkg::DivDenW:0]   rem_sh;
    logic [gcaf_pkg::DivDenW+1:0] trial;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    done_o = 1'b0;
    rem_sh = {rem_q, quo_q[gcaf_pkg::DivNumW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_q};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = gcaf_pkg::DivCntW'(gcaf_pkg::DivNumW);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (!trial[gcaf_pkg::DivDenW+1]) begin
          rem_d = trial[gcaf_pkg::DivDenW-1:0];
          quo_d = {quo_q[gcaf_pkg::DivNumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[gcaf_pkg::DivDenW-1:0];
          quo_d = {quo_q[gcaf_pkg::DivNumW-2:0], 1'b0};
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  // A new request never lands on a division in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

  // Completion follows a busy phase
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q && cnt_q == '0) else $error("done without busy");

  // Started division is busy next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q) else $error("start lost");

endmodule

// File: sim/tb_gated_complementary_attitude_filter_top.sv
// Self-checking testbench for the gated complementary attitude filter top level.
`timescale 1ns / 1ps

module tb_gated_complementary_attitude_filter_top;

  localparam int WatchdogLimit = 20000;
  localparam int NumRandom     = 1930;

  typedef struct packed {
    logic        acc_used;
    logic [9:0]  mag_pct;
    logic [15:0] sm_z, sm_y, sm_x;
    logic [23:0] mv_z, mv_y, mv_x;
    logic [23:0] gv_z, gv_y, gv_x;
  } filt_result_t;

  typedef struct packed {
    logic [23:0] mvi_z, mvi_y, mvi_x;
    logic [23:0] gvi_z, gvi_y, gvi_x;
    logic [15:0] mag_z, mag_y, mag_x;
    logic [15:0] acc_z, acc_y, acc_x;
  } imu_sample_t;

  // Filter predictor and expected-result store
  class filt_scoreboard;
    logic [14:0]   regs [4];
    longint        lowpass [3];
    filt_result_t  pending [$];
    int            errors;

    function void clear();
      regs[gcaf_pkg::REG_ACC_LPF_FACTOR]       = 15'(gcaf_pkg::LpfFactorRst);
      regs[gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT]  = 15'(gcaf_pkg::GravWRst);
      regs[gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT] = 15'(gcaf_pkg::MagWRst);
      regs[gcaf_pkg::REG_ONE_G_COUNTS]         = gcaf_pkg::OneGRst;
      foreach (lowpass[i]) lowpass[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(gcaf_pkg::reg_idx_e idx, logic [14:0] val);
      case (idx)
        gcaf_pkg::REG_ACC_LPF_FACTOR:       regs[idx] = val & 15'h7ff;
        gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT,
        gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT: regs[idx] = val & 15'hfff;
        default:                            regs[idx] = val;
      endcase
    endfunction

    function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Weighted blend, rounding half away from zero
    function logic [23:0] mix(longint est, longint v, longint w);
      longint den, num, q;
      den = w + 1;
      num = est * w + v * 256;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      return 24'(clamp(num < 0 ? -q : q, 24));
    endfunction

    function void note_sample(imu_sample_t s);
      filt_result_t r;
      longint f, g, a[3], sm[3], ge[3], me[3], mg[3], sumsq, magp, tilt, lp, x;
      bit tilt_ok, used;
      f = regs[gcaf_pkg::REG_ACC_LPF_FACTOR] != 0 ? regs[gcaf_pkg::REG_ACC_LPF_FACTOR] : 1;
      g = regs[gcaf_pkg::REG_ONE_G_COUNTS] != 0 ? regs[gcaf_pkg::REG_ONE_G_COUNTS] : 1;
      a  = '{$signed(s.acc_x), $signed(s.acc_y), $signed(s.acc_z)};
      mg = '{$signed(s.mag_x), $signed(s.mag_y), $signed(s.mag_z)};
      ge = '{$signed(s.gvi_x), $signed(s.gvi_y), $signed(s.gvi_z)};
      me = '{$signed(s.mvi_x), $signed(s.mvi_y), $signed(s.mvi_z)};
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        x = a[i] * 65536;
        lp = clamp(lowpass[i] + (x - lowpass[i]) / f, 32);
        lowpass[i] = lp;
        sm[i] = clamp(lp < 0 ? -((-lp) >>> 16) : (lp >>> 16), 16);
        sumsq += sm[i] * sm[i];
      end
      magp = sumsq * 100 / (g * g);
      tilt = g * 423 / 1000;
      tilt_ok = (sm[0] < 0 ? -sm[0] : sm[0]) < tilt &&
                (sm[1] < 0 ? -sm[1] : sm[1]) < tilt && sm[2] > 0;
      used = (magp > 36 && magp < 196) || tilt_ok;
      r.gv_x = used ? mix(ge[0], sm[0], regs[gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT]) : 24'(ge[0]);
      r.gv_y = used ? mix(ge[1], sm[1], regs[gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT]) : 24'(ge[1]);
      r.gv_z = used ? mix(ge[2], sm[2], regs[gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT]) : 24'(ge[2]);
      r.mv_x = mix(me[0], mg[0], regs[gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT]);
      r.mv_y = mix(me[1], mg[1], regs[gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT]);
      r.mv_z = mix(me[2], mg[2], regs[gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT]);
      r.sm_x = 16'(sm[0]);
      r.sm_y = 16'(sm[1]);
      r.sm_z = 16'(sm[2]);
      r.mag_pct = magp > 1023 ? 10'd1023 : 10'(magp);
      r.acc_used = used;
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [23:0] exp_v, logic [23:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(filt_result_t a);
      filt_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %0h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("grav_out_x", e.gv_x, a.gv_x);
      cmp("grav_out_y", e.gv_y, a.gv_y);
      cmp("grav_out_z", e.gv_z, a.gv_z);
      cmp("magv_out_x", e.mv_x, a.mv_x);
      cmp("magv_out_y", e.mv_y, a.mv_y);
      cmp("magv_out_z", e.mv_z, a.mv_z);
      cmp("smooth_acc_x", e.sm_x, a.sm_x);
      cmp("smooth_acc_y", e.sm_y, a.sm_y);
      cmp("smooth_acc_z", e.sm_z, a.sm_z);
      cmp("magnitude_percent", e.mag_pct, a.mag_pct);
      cmp("acc_used", e.acc_used, a.acc_used);
    endfunction
  endclass

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic [gcaf_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tvalid = 0;
  logic                          s_axis_tready;
  logic [gcaf_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 0;
  logic                          cfg_valid_i = 0;
  logic                          cfg_ready_o;
  logic [1:0]                    cfg_addr_i = '0;
  logic [14:0]                   cfg_data_i = '0;

  filt_scoreboard sb = new();
  bit             quiet_phase = 0;
  int             idle_cycles = 0;

  gated_complementary_attitude_filter_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Result sink with random stall bursts
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(filt_result_t'(m_axis_tdata[202:0]));
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 12);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= rst_ni;
      end
    end
  end

  // Watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(imu_sample_t s);
    @(posedge clk_i);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tdata  <= s;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
    s_axis_tvalid <= 0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(gcaf_pkg::reg_idx_e idx, logic [14:0] val);
    @(posedge clk_i);
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  task automatic set_regs(logic [14:0] f, logic [14:0] wg, logic [14:0] wm, logic [14:0] g);
    write_reg(gcaf_pkg::REG_ACC_LPF_FACTOR, f);
    write_reg(gcaf_pkg::REG_GRAVITY_GYRO_WEIGHT, wg);
    write_reg(gcaf_pkg::REG_MAGNETIC_GYRO_WEIGHT, wm);
    write_reg(gcaf_pkg::REG_ONE_G_COUNTS, g);
  endtask

  // Fully random item
  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    s = imu_sample_t'(240'({$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom}));
    return s;
  endfunction

  // Plausible sensor item: acceleration near one g so the gate toggles
  function automatic imu_sample_t sane_sample(int g);
    imu_sample_t s;
    int span;
    s = rand_sample();
    span = g * 3 / 2 + 1;
    s.acc_x = 16'($signed($urandom_range(0, 2 * span)) - span);
    s.acc_y = 16'($signed($urandom_range(0, 2 * span)) - span);
    s.acc_z = 16'($signed($urandom_range(0, 2 * span)) - span / 3);
    if ($urandom_range(0, 1)) begin
      s.gvi_x = {{12{s.gvi_x[11]}}, s.gvi_x[11:0]};
      s.gvi_y = {{12{s.gvi_y[11]}}, s.gvi_y[11:0]};
      s.gvi_z = {{12{s.gvi_z[11]}}, s.gvi_z[11:0]};
    end
    return s;
  endfunction

  initial begin
    imu_sample_t s;
    int g;
    sb.clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes with reset settings
    s = '0;
    send_sample(s);
    s = {{6{24'h7fffff}}, {6{16'h7fff}}};
    repeat (3) send_sample(s);
    s = {{6{24'h800000}}, {6{16'h8000}}};
    repeat (3) send_sample(s);
    s = '0;
    s.acc_z = 16'd512;
    repeat (4) send_sample(s);
    wait_drained();

    // Directed: zero divisors, weights and one g, then upper extremes
    set_regs(15'd0, 15'd0, 15'd0, 15'd0);
    send_sample({{6{24'h7fffff}}, {6{16'h8000}}});
    send_sample({{6{24'h800000}}, {6{16'h7fff}}});
    s = '0;
    s.acc_z = 16'd1;
    send_sample(s);
    wait_drained();
    set_regs(15'd1024, 15'd4095, 15'd4095, 15'd16384);
    send_sample({{6{24'h7fffff}}, {6{16'h7fff}}});
    send_sample({{6{24'h800000}}, {6{16'h8000}}});
    s = '0;
    s.acc_z = 16'd16384;
    send_sample(s);
    // Max-width register values exercise masking
    wait_drained();
    set_regs(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    send_sample(rand_sample());
    send_sample(sane_sample(16384));
    wait_drained();

    // Random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(15'd1, 15'd1, 15'd1, 15'd1);
        1: set_regs(15'd100, 15'd400, 15'd200, 15'd512);
        2: set_regs(15'd1024, 15'd4095, 15'd4095, 15'd16384);
        default: set_regs(15'($urandom_range(1, 8)), 15'($urandom_range(1, 4095)),
                          15'($urandom_range(1, 4095)), 15'($urandom_range(1, 16384)));
      endcase
      g = sb.regs[gcaf_pkg::REG_ONE_G_COUNTS] == 0 ? 1 : sb.regs[gcaf_pkg::REG_ONE_G_COUNTS];
      if (ph == 7) quiet_phase = 1;
      for (int k = 0; k < NumRandom / 8; k++) begin
        send_sample($urandom_range(0, 4) == 0 ? rand_sample() : sane_sample(g));
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
